// File: sv/rhh_pkg.sv
// ----------------------------------------------------------------------------
// rhh_pkg
// Shared constants and types for the RGB to HSL/HWB converter.
// ----------------------------------------------------------------------------
package rhh_pkg;

   localparam int HUE_FRAC_BITS_DEF  = 6;
   localparam int UNIT_FRAC_BITS_DEF = 12;

   localparam int BYTE_W = 8;
   localparam int HUE_W  = 15;
   localparam int UNIT_W = 13;
   localparam int DEN_W  = 10;

   localparam int NUM_LANES  = 2;
   localparam int LANE_SAT   = 0;
   localparam int LANE_HUE   = 1;

   // floor(y / 255) = (y * LIGHT_RECIP) >> LIGHT_SHIFT, exact for y < 2^24
   localparam logic [24:0] LIGHT_RECIP = 25'd16843010;
   localparam int          LIGHT_SHIFT = 32;

   localparam logic [8:0]       HALF_SUM   = 9'd255;
   localparam logic [8:0]       FULL_SUM   = 9'd510;

   typedef struct packed {
      logic [UNIT_W-1:0] light;
      logic [BYTE_W-1:0] mn;
      logic [BYTE_W-1:0] blk;
      logic              achro;
   } side_type;

endpackage

// File: sv/rhh_if.sv
// ----------------------------------------------------------------------------
// rhh_req_if / rhh_rsp_if
// Valid/ready channels for pixel requests and conversion responses.
// ----------------------------------------------------------------------------
interface rhh_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;

   modport source (output valid, red, green, blue, input ready);
   modport sink   (input valid, red, green, blue, output ready);
endinterface

interface rhh_rsp_if;
   logic        valid;
   logic        ready;
   logic [14:0] hue;
   logic [12:0] saturation;
   logic [12:0] lightness;
   logic [7:0]  whiteness;
   logic [7:0]  blackness;
   logic        achromatic;

   modport source (output valid, hue, saturation, lightness, whiteness, blackness,
                   achromatic, input ready);
   modport sink   (input valid, hue, saturation, lightness, whiteness, blackness,
                   achromatic, output ready);
endinterface

// File: sv/rgb_to_hsl_hwb_unit.sv
// ----------------------------------------------------------------------------
// rgb_to_hsl_hwb_unit
// Converts an 8-bit RGB pixel to HSL plus HWB whiteness and blackness.
// ----------------------------------------------------------------------------
// One pixel is accepted per clock while no stage stalls. A transaction passes
// QW + 2 register stages, with QW = max(UNIT_FRAC_BITS + 1, HUE_FRAC_BITS + 9)
// (15 at the defaults): one front stage that also forms lightness, a chain of
// QW restoring-division cells that each settle one quotient bit of hue and
// saturation, and the output register. Every stage holds its transaction only
// while the stage after it is full.
// ----------------------------------------------------------------------------
module rgb_to_hsl_hwb_unit #(
   parameter int HUE_FRAC_BITS  = rhh_pkg::HUE_FRAC_BITS_DEF,
   parameter int UNIT_FRAC_BITS = rhh_pkg::UNIT_FRAC_BITS_DEF
) (
   input logic      clock,
   input logic      reset,
   rhh_req_if.sink   req_if,
   rhh_rsp_if.source rsp_if
);
   import rhh_pkg::*;

   localparam int QW = (UNIT_FRAC_BITS + 1 > HUE_FRAC_BITS + 9) ?
                       UNIT_FRAC_BITS + 1 : HUE_FRAC_BITS + 9;
   localparam int RW = QW + DEN_W;

   logic                         vld_s  [0:QW];
   logic                         en_s   [0:QW];
   logic [NUM_LANES-1:0][RW-1:0] rem_s  [0:QW];
   logic [NUM_LANES-1:0][RW-1:0] dv_s   [0:QW];
   logic [NUM_LANES-1:0][QW-1:0] q_s    [0:QW];
   side_type                     side_s [0:QW];

   logic [QW-1:0] hue_q, hue_w, full_turn;
   logic          out_en;
   logic          vld_ff;
   logic [HUE_W-1:0]  hue_ff, hue_in;
   logic [UNIT_W-1:0] sat_ff, sat_in;
   side_type          side_ff;

   rhh_prep #(
      .HFB (HUE_FRAC_BITS),
      .UFB (UNIT_FRAC_BITS),
      .QW  (QW),
      .RW  (RW)
   ) u_prep (
      .clock  (clock),
      .reset  (reset),
      .vld_i  (req_if.valid),
      .red    (req_if.red),
      .green  (req_if.green),
      .blue   (req_if.blue),
      .dn_en  (en_s[0]),
      .up_en  (req_if.ready),
      .vld_o  (vld_s[0]),
      .rem_o  (rem_s[0]),
      .dv_o   (dv_s[0]),
      .side_o (side_s[0])
   );

   assign q_s[0] = '0;

   for (genvar k = 1; k <= QW; k++) begin : g_cell
      rhh_cell #(
         .QW (QW),
         .RW (RW)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .dn_en  (en_s[k]),
         .up_en  (en_s[k-1]),
         .vld_i  (vld_s[k-1]),
         .rem_i  (rem_s[k-1]),
         .dv_i   (dv_s[k-1]),
         .q_i    (q_s[k-1]),
         .side_i (side_s[k-1]),
         .vld_o  (vld_s[k]),
         .rem_o  (rem_s[k]),
         .dv_o   (dv_s[k]),
         .q_o    (q_s[k]),
         .side_o (side_s[k])
      );
   end

   assign out_en    = !vld_ff || rsp_if.ready;
   assign en_s[QW]  = out_en;
   assign full_turn = QW'(360) << HUE_FRAC_BITS;
   assign hue_q     = q_s[QW][LANE_HUE];
   assign hue_w     = (hue_q >= full_turn) ? hue_q - full_turn : hue_q;
   assign hue_in    = side_s[QW].achro ? '0 : HUE_W'(hue_w);
   assign sat_in    = side_s[QW].achro ? '0 : UNIT_W'(q_s[QW][LANE_SAT]);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (out_en) begin
         vld_ff <= vld_s[QW];
      end
   end

   always_ff @(posedge clock) begin
      if (out_en) begin
         hue_ff   <= hue_in;
         sat_ff   <= sat_in;
         side_ff  <= side_s[QW];
      end
   end

   assign rsp_if.valid      = vld_ff;
   assign rsp_if.hue        = hue_ff;
   assign rsp_if.saturation = sat_ff;
   assign rsp_if.lightness  = side_ff.light;
   assign rsp_if.whiteness  = side_ff.mn;
   assign rsp_if.blackness  = side_ff.blk;
   assign rsp_if.achromatic = side_ff.achro;

   a_achro_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.achromatic |-> rsp_if.hue == '0 && rsp_if.saturation == '0)
      else $error("achromatic response with nonzero hue or saturation");

   a_min_max: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> ({1'b0, rsp_if.whiteness} + {1'b0, rsp_if.blackness}) <= 9'd255)
      else $error("whiteness exceeds maximum channel");

   a_front_load: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready |=> vld_s[0])
      else $error("accepted transaction lost at front stage");

endmodule

// File: sv/rhh_prep.sv
// ----------------------------------------------------------------------------
// rhh_prep
// Front stage: min/max, lightness, sector numerator and divider operands.
// ----------------------------------------------------------------------------
module rhh_prep #(
   parameter int HFB = rhh_pkg::HUE_FRAC_BITS_DEF,
   parameter int UFB = rhh_pkg::UNIT_FRAC_BITS_DEF,
   parameter int QW  = 19,
   parameter int RW  = 29
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     vld_i,
   input  logic [7:0]                               red,
   input  logic [7:0]                               green,
   input  logic [7:0]                               blue,
   input  logic                                     dn_en,
   output logic                                     up_en,
   output logic                                     vld_o,
   output logic [rhh_pkg::NUM_LANES-1:0][RW-1:0]    rem_o,
   output logic [rhh_pkg::NUM_LANES-1:0][RW-1:0]    dv_o,
   output rhh_pkg::side_type                        side_o
);
   import rhh_pkg::*;

   logic [7:0]  mx, mn, d;
   logic [8:0]  s, sden;
   logic [10:0] d11, six;
   logic [17:0] hue60;
   logic [24:0] lt_x;
   logic [48:0] lt_p;
   logic [NUM_LANES-1:0][RW-1:0] rem_in, dv_in;
   logic [NUM_LANES-1:0][RW-1:0] rem_ff, dv_ff;
   side_type side_in, side_ff;
   logic vld_ff;

   always_comb begin
      mx = red;
      mn = red;
      if (green > mx) mx = green;
      if (blue > mx) mx = blue;
      if (green < mn) mn = green;
      if (blue < mn) mn = blue;
      d    = mx - mn;
      s    = {1'b0, mx} + {1'b0, mn};
      sden = (s <= HALF_SUM) ? s : FULL_SUM - s;
      d11  = {3'b0, d};
      if (mx == red) begin
         if (green >= blue) six = {3'b0, green - blue};
         else six = 11'(d11 * 11'd6) - {3'b0, blue - green};
      end else if (mx == green) begin
         six = 11'(d11 * 11'd2) + {3'b0, blue} - {3'b0, red};
      end else begin
         six = 11'(d11 * 11'd4) + {3'b0, red} - {3'b0, green};
      end
      hue60 = 18'({7'b0, six} * 18'd120);

      // lightness = floor((s * 2^UFB + 255) / 510), halved then divided by 255
      lt_x = (25'(s) << UFB) + 25'd255;
      lt_p = 49'({25'b0, lt_x[24:1]} * 49'(LIGHT_RECIP));

      rem_in[LANE_SAT]   = (RW'(d) << (UFB + 1)) + RW'(sden);
      dv_in[LANE_SAT]    = RW'({sden, 1'b0}) << (QW - 1);
      rem_in[LANE_HUE]   = (RW'(hue60) << HFB) + RW'(d);
      dv_in[LANE_HUE]    = RW'({d, 1'b0}) << (QW - 1);

      side_in.light = UNIT_W'(lt_p >> LIGHT_SHIFT);
      side_in.mn    = mn;
      side_in.blk   = 8'd255 - mx;
      side_in.achro = (d == 8'd0);
   end

   assign up_en = !vld_ff || dn_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (up_en) begin
         vld_ff <= vld_i;
      end
   end

   always_ff @(posedge clock) begin
      if (up_en) begin
         rem_ff  <= rem_in;
         dv_ff   <= dv_in;
         side_ff <= side_in;
      end
   end

   assign vld_o  = vld_ff;
   assign rem_o  = rem_ff;
   assign dv_o   = dv_ff;
   assign side_o = side_ff;

endmodule

// File: sv/rhh_cell.sv
// ----------------------------------------------------------------------------
// rhh_cell
// One restoring-division step for all lanes; yields one quotient bit each.
// ----------------------------------------------------------------------------
module rhh_cell #(
   parameter int QW = 19,
   parameter int RW = 29
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  dn_en,
   output logic                                  up_en,
   input  logic                                  vld_i,
   input  logic [rhh_pkg::NUM_LANES-1:0][RW-1:0] rem_i,
   input  logic [rhh_pkg::NUM_LANES-1:0][RW-1:0] dv_i,
   input  logic [rhh_pkg::NUM_LANES-1:0][QW-1:0] q_i,
   input  rhh_pkg::side_type                     side_i,
   output logic                                  vld_o,
   output logic [rhh_pkg::NUM_LANES-1:0][RW-1:0] rem_o,
   output logic [rhh_pkg::NUM_LANES-1:0][RW-1:0] dv_o,
   output logic [rhh_pkg::NUM_LANES-1:0][QW-1:0] q_o,
   output rhh_pkg::side_type                     side_o
);
   import rhh_pkg::*;

   logic [NUM_LANES-1:0][RW-1:0] rem_in, dv_in, rem_ff, dv_ff;
   logic [NUM_LANES-1:0][QW-1:0] q_in, q_ff;
   side_type side_ff;
   logic vld_ff;

   always_comb begin
      for (int l = 0; l < NUM_LANES; l++) begin
         if (rem_i[l] >= dv_i[l]) begin
            rem_in[l] = rem_i[l] - dv_i[l];
            q_in[l]   = {q_i[l][QW-2:0], 1'b1};
         end else begin
            rem_in[l] = rem_i[l];
            q_in[l]   = {q_i[l][QW-2:0], 1'b0};
         end
         dv_in[l] = dv_i[l] >> 1;
      end
   end

   assign up_en = !vld_ff || dn_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (up_en) begin
         vld_ff <= vld_i;
      end
   end

   always_ff @(posedge clock) begin
      if (up_en) begin
         rem_ff  <= rem_in;
         dv_ff   <= dv_in;
         q_ff    <= q_in;
         side_ff <= side_i;
      end
   end

   assign vld_o  = vld_ff;
   assign rem_o  = rem_ff;
   assign dv_o   = dv_ff;
   assign q_o    = q_ff;
   assign side_o = side_ff;

endmodule
